// ----- design/a429tx_pkg.sv -----
package a429tx_pkg;

    localparam int WORD_BITS     = 32;
    localparam int BIT_IDX_W     = 6;
    localparam int PRESSURE_W    = 21;
    localparam int PRESSURE_LSB  = 10;
    localparam int LABEL_W       = 8;
    localparam int TICKS_W       = 16;
    localparam int GAP_W         = 8;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LABEL_CODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_HALF_BITS  = 2'd2;

    localparam logic [LABEL_W-1:0] LABEL_RESET = 8'd174;
    localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd40;
    localparam logic [GAP_W-1:0]   GAP_RESET   = 8'd8;

    localparam logic [BIT_IDX_W-1:0] GAP_INDEX = BIT_IDX_W'(WORD_BITS);

    typedef struct packed {
        logic line_a;
        logic line_b;
        logic busy_res;
        logic word_sent;
    } a429tx_result_t;

    function automatic logic [WORD_BITS-1:0] build_word(
        input logic [LABEL_W-1:0]    label,
        input logic [PRESSURE_W-1:0] pressure
    );
        logic [WORD_BITS-1:0] w;
        begin
            w = '0;
            w[LABEL_W-1:0] = label;
            w[PRESSURE_LSB +: PRESSURE_W] = pressure;
            w[WORD_BITS-1] = ~(^w[WORD_BITS-2:0]);
            return w;
        end
    endfunction

endpackage

// ----- design/arinc429_word_transmitter_top.sv -----
// A word's result is registered in the result register, or in the skid
// register while the result register is held. Throughput: one word per
// cycle while the skid register is empty; the two-entry output buffer
// keeps input and output apart. Reset (rst_n, async, active low): idle,
// buffer empty, label 174, 40 ticks per half bit, gap of 8 half bits.
module arinc429_word_transmitter_top
    import a429tx_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  start_req,
    input  logic [PRESSURE_W-1:0] pressure_value,
    input  logic                  tick,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  line_a,
    output logic                  line_b,
    output logic                  busy_res,
    output logic                  word_sent
);

    logic [LABEL_W-1:0] label_reg;
    logic [TICKS_W-1:0] half_ticks_reg;
    logic [GAP_W-1:0]   gap_bits_reg;

    logic [WORD_BITS-1:0] word_reg,   word_next;
    logic [BIT_IDX_W-1:0] bit_idx_reg, bit_idx_next;
    logic                 null_reg,   null_next;
    logic [TICKS_W-1:0]   tcnt_reg,   tcnt_next;
    logic [GAP_W-1:0]     gcnt_reg,   gcnt_next;
    logic                 send_reg,   send_next;

    a429tx_result_t res_next, out_reg, skid_reg;
    logic           out_valid_reg, skid_valid_reg;

    logic             in_acc;
    logic             out_pop;
    logic [TICKS_W:0] t_inc;
    logic [TICKS_W:0] limit;
    logic [GAP_W-1:0] g_inc;
    logic             done;

    assign in_ready = ~skid_valid_reg;
    assign in_acc   = in_valid & in_ready;
    assign out_pop  = out_valid_reg & out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            label_reg      <= LABEL_RESET;
            half_ticks_reg <= TICKS_RESET;
            gap_bits_reg   <= GAP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LABEL_CODE:     label_reg      <= cfg_data[LABEL_W-1:0];
                CFG_HALF_BIT_TICKS: half_ticks_reg <= cfg_data[TICKS_W-1:0];
                CFG_GAP_HALF_BITS:  gap_bits_reg   <= cfg_data[GAP_W-1:0];
                default:            ;
            endcase
        end
    end

    // next state of the serializer for the word being accepted
    always_comb
    begin
        word_next    = word_reg;
        bit_idx_next = bit_idx_reg;
        null_next    = null_reg;
        tcnt_next    = tcnt_reg;
        gcnt_next    = gcnt_reg;
        send_next    = send_reg;
        done         = 1'b0;
        limit        = (half_ticks_reg == '0) ? (TICKS_W+1)'(1)
                                              : {1'b0, half_ticks_reg};
        t_inc        = {1'b0, tcnt_reg} + (TICKS_W+1)'(1);
        g_inc        = gcnt_reg + GAP_W'(1);

        if (!send_reg)
        begin
            if (start_req)
            begin
                word_next    = build_word(label_reg, pressure_value);
                bit_idx_next = '0;
                null_next    = 1'b0;
                tcnt_next    = '0;
                gcnt_next    = '0;
                send_next    = 1'b1;
            end
        end
        else if (tick)
        begin
            if (t_inc >= limit)
            begin
                tcnt_next = '0;
                if (bit_idx_reg < GAP_INDEX)
                begin
                    if (!null_reg)
                    begin
                        null_next = 1'b1;
                    end
                    else
                    begin
                        null_next    = 1'b0;
                        bit_idx_next = bit_idx_reg + BIT_IDX_W'(1);
                        if (bit_idx_next >= GAP_INDEX && gap_bits_reg == '0)
                        begin
                            done = 1'b1;
                        end
                    end
                end
                else
                begin
                    gcnt_next = g_inc;
                    if (g_inc >= gap_bits_reg)
                    begin
                        done = 1'b1;
                    end
                end
            end
            else
            begin
                tcnt_next = t_inc[TICKS_W-1:0];
            end
        end

        if (done)
        begin
            send_next    = 1'b0;
            bit_idx_next = '0;
            null_next    = 1'b0;
            tcnt_next    = '0;
            gcnt_next    = '0;
        end

        res_next.line_a    = 1'b0;
        res_next.line_b    = 1'b0;
        res_next.busy_res  = send_next;
        res_next.word_sent = done;
        if (send_next && bit_idx_next < GAP_INDEX && !null_next)
        begin
            res_next.line_a = word_next[bit_idx_next[BIT_IDX_W-2:0]];
            res_next.line_b = ~word_next[bit_idx_next[BIT_IDX_W-2:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg    <= '0;
            bit_idx_reg <= '0;
            null_reg    <= 1'b0;
            tcnt_reg    <= '0;
            gcnt_reg    <= '0;
            send_reg    <= 1'b0;
        end
        else if (in_acc)
        begin
            word_reg    <= word_next;
            bit_idx_reg <= bit_idx_next;
            null_reg    <= null_next;
            tcnt_reg    <= tcnt_next;
            gcnt_reg    <= gcnt_next;
            send_reg    <= send_next;
        end
    end

    // result register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_acc;
            end
        end
        else if (in_acc)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_pop)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (in_acc)
            begin
                out_reg <= res_next;
            end
        end
        else if (in_acc)
        begin
            skid_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign line_a    = out_reg.line_a;
    assign line_b    = out_reg.line_b;
    assign busy_res  = out_reg.busy_res;
    assign word_sent = out_reg.word_sent;

    a_lines_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.line_a && out_reg.line_b))
        else $error("line_a and line_b both driven");

    a_sent_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.word_sent) |-> !out_reg.busy_res)
        else $error("word_sent while still busy");

    a_drive_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.line_a || out_reg.line_b)) |-> out_reg.busy_res)
        else $error("line driven while idle");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a word while result register is empty");

    a_idle_state_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !send_reg |-> (bit_idx_reg == '0 && !null_reg && tcnt_reg == '0))
        else $error("serializer counters not cleared while idle");

endmodule

// ----- verif/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import a429tx_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int RUN_LIMIT    = 200000;
    localparam int HOLD_CYCLES  = 150;
    localparam int HOLD_AT_WORD = 600;
    localparam int SETTLE       = 6;

    typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

    // res order: line_a, line_b, busy_res, word_sent
    typedef struct packed {
        row_kind_t             kind;
        logic                  go;
        logic [PRESSURE_W-1:0] hpa;
        logic                  tk;
        logic                  typed;
        a429tx_result_t        res;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
    } script_row_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] label_data;
        logic [CFG_DATA_W-1:0] ticks_data;
        logic [CFG_DATA_W-1:0] gap_data;
        logic [11:0]           count;
        logic                  quiet;
    } line_phase_t;

    localparam script_row_t SCRIPT [16] = '{
        '{ROW_WORD, 1'b0, 21'h000000, 1'b0, 1'b1, 4'b0000, CFG_LABEL_CODE, 16'h0000},
        '{ROW_WORD, 1'b0, 21'h1FFFFF, 1'b1, 1'b1, 4'b0000, CFG_LABEL_CODE, 16'h0000},
        '{ROW_WORD, 1'b1, 21'h1FFFFF, 1'b1, 1'b1, 4'b0110, CFG_LABEL_CODE, 16'h0000},
        '{ROW_WORD, 1'b1, 21'h000000, 1'b1, 1'b1, 4'b0110, CFG_LABEL_CODE, 16'h0000},
        '{ROW_WORD, 1'b0, 21'h000000, 1'b0, 1'b1, 4'b0110, CFG_LABEL_CODE, 16'h0000},
        '{ROW_REG,  1'b0, 21'h000000, 1'b0, 1'b0, 4'b0000, CFG_LABEL_CODE, 16'hFFFF},
        '{ROW_REG,  1'b0, 21'h000000, 1'b0, 1'b0, 4'b0000, CFG_HALF_BIT_TICKS, 16'h0000},
        '{ROW_REG,  1'b0, 21'h000000, 1'b0, 1'b0, 4'b0000, CFG_GAP_HALF_BITS, 16'h0000},
        '{ROW_WORD, 1'b0, 21'h000000, 1'b1, 1'b0, 4'b0000, CFG_LABEL_CODE, 16'h0000},
        '{ROW_WORD, 1'b0, 21'h0AAAAA, 1'b1, 1'b0, 4'b0000, CFG_LABEL_CODE, 16'h0000},
        '{ROW_WORD, 1'b1, 21'h155555, 1'b1, 1'b0, 4'b0000, CFG_LABEL_CODE, 16'h0000},
        '{ROW_REG,  1'b0, 21'h000000, 1'b0, 1'b0, 4'b0000, CFG_HALF_BIT_TICKS, 16'hFFFF},
        '{ROW_WORD, 1'b0, 21'h000000, 1'b1, 1'b0, 4'b0000, CFG_LABEL_CODE, 16'h0000},
        '{ROW_REG,  1'b0, 21'h000000, 1'b0, 1'b0, 4'b0000, CFG_LABEL_CODE, 16'h0000},
        '{ROW_REG,  1'b0, 21'h000000, 1'b0, 1'b0, 4'b0000, CFG_GAP_HALF_BITS, 16'h00FF},
        '{ROW_REG,  1'b0, 21'h000000, 1'b0, 1'b0, 4'b0000, CFG_UNUSED, 16'hFFFF}
    };

    localparam line_phase_t PHASES [6] = '{
        '{16'h003C, 16'h0001, 16'h0000, 12'd350, 1'b0},
        '{16'h00FF, 16'h0000, 16'h0001, 12'd350, 1'b0},
        '{16'hA55A, 16'h0001, 16'hFFFF, 12'd350, 1'b1},
        '{16'h0000, 16'h0002, 16'h0003, 12'd350, 1'b0},
        '{16'h0081, 16'hFFFF, 16'h0008, 12'd100, 1'b0},
        '{16'h00E7, 16'h0001, 16'h0002, 12'd350, 1'b0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic                  start_req;
    logic [PRESSURE_W-1:0] pressure_value;
    logic                  tick;
    logic                  out_valid;
    logic                  out_ready;
    logic                  line_a;
    logic                  line_b;
    logic                  busy_res;
    logic                  word_sent;

    // line model
    logic [WORD_BITS-1:0]  tx_word;
    logic [BIT_IDX_W-1:0]  tx_bit;
    logic                  tx_null;
    logic [TICKS_W-1:0]    tx_ticks;
    logic [GAP_W-1:0]      tx_gap;
    logic                  tx_busy;
    logic [LABEL_W-1:0]    set_label;
    logic [TICKS_W-1:0]    set_ticks;
    logic [GAP_W-1:0]      set_gap;

    a429tx_result_t line_expect_q [$];
    a429tx_result_t want;
    int             words_in = 0;
    int             fails = 0;
    int             cycles = 0;
    int             hold_left = 0;
    bit             held = 1'b0;
    bit             quiet = 1'b0;

    arinc429_word_transmitter_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .start_req      (start_req),
        .pressure_value (pressure_value),
        .tick           (tick),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .line_a         (line_a),
        .line_b         (line_b),
        .busy_res       (busy_res),
        .word_sent      (word_sent)
    );

    always #5 clk = ~clk;

    function automatic void clear_tx();
        tx_busy  = 1'b0;
        tx_bit   = '0;
        tx_null  = 1'b0;
        tx_ticks = '0;
        tx_gap   = '0;
    endfunction

    function automatic a429tx_result_t line_step(input logic go,
                                                 input logic [PRESSURE_W-1:0] hpa,
                                                 input logic tk);
        a429tx_result_t r;
        logic [TICKS_W:0] limit;
        logic [TICKS_W:0] next_tick;
        r = '0;
        if (!tx_busy) begin
            if (go) begin
                tx_word = {1'b0, hpa, 2'b00, set_label};
                tx_word[WORD_BITS-1] = ~(^tx_word[WORD_BITS-2:0]);
                clear_tx();
                tx_busy = 1'b1;
            end
        end
        else if (tk) begin
            limit = (set_ticks == '0) ? 17'd1 : {1'b0, set_ticks};
            next_tick = {1'b0, tx_ticks} + 17'd1;
            if (next_tick >= limit) begin
                tx_ticks = '0;
                if (tx_bit < GAP_INDEX) begin
                    if (!tx_null) begin
                        tx_null = 1'b1;
                    end
                    else begin
                        tx_null = 1'b0;
                        tx_bit = tx_bit + BIT_IDX_W'(1);
                        if (tx_bit == GAP_INDEX && set_gap == '0) begin
                            clear_tx();
                            r.word_sent = 1'b1;
                        end
                    end
                end
                else begin
                    tx_gap = tx_gap + GAP_W'(1);
                    if (tx_gap >= set_gap) begin
                        clear_tx();
                        r.word_sent = 1'b1;
                    end
                end
            end
            else begin
                tx_ticks = next_tick[TICKS_W-1:0];
            end
        end
        if (tx_busy && tx_bit < GAP_INDEX && !tx_null) begin
            r.line_a = tx_word[tx_bit[4:0]];
            r.line_b = ~r.line_a;
        end
        r.busy_res = tx_busy;
        return r;
    endfunction

    task automatic offer_word(input logic go, input logic [PRESSURE_W-1:0] hpa,
                              input logic tk, input logic typed,
                              input a429tx_result_t typed_res);
        a429tx_result_t r;
        cfg_we <= 1'b0;
        while (!quiet && $urandom_range(99) < 24) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        start_req      <= go;
        pressure_value <= hpa;
        tick           <= tk;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        r = line_step(go, hpa, tk);
        line_expect_q.push_back(typed ? typed_res : r);
        words_in++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        cfg_we   <= 1'b0;
        while (line_expect_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_LABEL_CODE:     set_label = data[LABEL_W-1:0];
            CFG_HALF_BIT_TICKS: set_ticks = data[TICKS_W-1:0];
            CFG_GAP_HALF_BITS:  set_gap   = data[GAP_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // receiver
    initial begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (!held && words_in >= HOLD_AT_WORD) begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= quiet || ($urandom_range(99) >= 24);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (line_expect_q.size() == 0) begin
                $error("word with nothing expected: a=%0b b=%0b busy=%0b sent=%0b",
                       line_a, line_b, busy_res, word_sent);
                fails++;
            end
            else begin
                want = line_expect_q.pop_front();
                if (line_a !== want.line_a) begin
                    $error("line_a: expected %0b, got %0b", want.line_a, line_a);
                    fails++;
                end
                if (line_b !== want.line_b) begin
                    $error("line_b: expected %0b, got %0b", want.line_b, line_b);
                    fails++;
                end
                if (busy_res !== want.busy_res) begin
                    $error("busy_res: expected %0b, got %0b", want.busy_res, busy_res);
                    fails++;
                end
                if (word_sent !== want.word_sent) begin
                    $error("word_sent: expected %0b, got %0b", want.word_sent, word_sent);
                    fails++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        logic                  go;
        logic [PRESSURE_W-1:0] hpa;
        logic                  tk;
        line_phase_t           ph;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_LABEL_CODE;
        cfg_data       = '0;
        in_valid       = 1'b0;
        start_req      = 1'b0;
        pressure_value = '0;
        tick           = 1'b0;
        set_label      = LABEL_RESET;
        set_ticks      = TICKS_RESET;
        set_gap        = GAP_RESET;
        tx_word        = '0;
        clear_tx();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (SCRIPT[i]) begin
            if (SCRIPT[i].kind == ROW_REG)
                write_reg(SCRIPT[i].reg_idx, SCRIPT[i].reg_data);
            else
                offer_word(SCRIPT[i].go, SCRIPT[i].hpa, SCRIPT[i].tk,
                           SCRIPT[i].typed, SCRIPT[i].res);
        end

        foreach (PHASES[p]) begin
            ph = PHASES[p];
            write_reg(CFG_LABEL_CODE, ph.label_data);
            write_reg(CFG_HALF_BIT_TICKS, ph.ticks_data);
            write_reg(CFG_GAP_HALF_BITS, ph.gap_data);
            quiet = ph.quiet;
            for (int k = 0; k < ph.count; k++) begin
                go = tx_busy ? ($urandom_range(9) == 0) : ($urandom_range(1) == 1);
                case ($urandom_range(7))
                    0:       hpa = '0;
                    1:       hpa = '1;
                    default: hpa = PRESSURE_W'($urandom);
                endcase
                tk = ($urandom_range(7) != 0);
                offer_word(go, hpa, tk, 1'b0, '0);
            end
            quiet = 1'b0;
        end

        drain();
        repeat (10) @(posedge clk);
        if (fails == 0 && line_expect_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- arinc429_word_transmitter_top.f -----
design/a429tx_pkg.sv
design/arinc429_word_transmitter_top.sv
verif/testbench.sv
